// File: hw/rtl/round_robin_task_scheduler_defines.svh
// Assertion macros for the round-robin task scheduler
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/rrts_pkg.sv
// Shared constants and types for the round-robin task scheduler
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int SLOT_W    = $clog2(NUM_TASKS);
    localparam int DATA_W    = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_DELAY  = 2'd1;
    localparam logic [1:0] OP_SWITCH = 2'd2;
    localparam logic [1:0] OP_INIT   = 2'd3;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;

    typedef struct packed {
        logic              sub;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

endpackage

// File: hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with per-entry valid bits (invalid reads zero)
`timescale 1ns / 1ps

module rrts_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rrts_alu.sv
// Shared 32-bit add / compare unit
`timescale 1ns / 1ps

module rrts_alu (
    input  rrts_pkg::t_alu_req            i_req,
    output logic [rrts_pkg::DATA_W-1:0]   o_sum,
    output logic                          o_ge
);

    logic [rrts_pkg::DATA_W:0]   w_full;
    logic [rrts_pkg::DATA_W-1:0] w_b;

    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{rrts_pkg::DATA_W{1'b0}}, i_req.sub};
    assign o_sum  = w_full[rrts_pkg::DATA_W-1:0];
    // carry out of a - b means no borrow
    assign o_ge   = w_full[rrts_pkg::DATA_W];

endmodule

// File: hw/rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler: slot state, sequencer and result register
// Path from acceptance to result valid: tick S_WAKE, S_WLAST, S_RD, S_OUT; switch
// S_SCAN, S_RD, S_OUT; delay and init S_RD, S_OUT. One item in work at a time; on a
// tick the sequencer walks the slots one per cycle through the shared add/compare unit
// and wake-time RAM. A new item is taken once the last has left S_OUT, even while a
// result waits. Sync active-low reset: slot 0 running, others blocked, counters zero.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_defines.svh"

module round_robin_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_delay_amount,
    input  logic [31:0] i_stack_pointer,
    input  logic [2:0]  i_task_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_running_task,
    output logic [31:0] o_resume_pointer,
    output logic        o_switch_request
);

    localparam int SW = rrts_pkg::SLOT_W;
    localparam int NT = rrts_pkg::NUM_TASKS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAKE  = 3'd1;
    localparam logic [2:0] S_WLAST = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [31:0]                 r_tick, n_tick;
    logic [SW-1:0]               r_cur, n_cur;
    logic [SW-1:0]               r_idx, n_idx;
    logic [SW-1:0]               r_cnt, n_cnt;
    logic [SW-1:0]               r_chk, n_chk;
    logic                        r_chk_v, n_chk_v;
    logic                        r_req, n_req;
    logic [1:0]                  r_ts [NT];
    logic [1:0]                  n_ts [NT];
    logic                        r_out_valid;
    logic [2:0]                  r_out_task;
    logic [31:0]                 r_out_ptr;
    logic                        r_out_req;

    logic                        w_in_acc;
    logic                        w_load;
    logic                        w_hit;
    logic                        w_slot_ok;
    logic [SW-1:0]               w_slot;
    logic [NT-1:0]               w_ready;
    logic [NT-1:0]               w_running;
    rrts_pkg::t_alu_req          w_alu_req;
    logic [31:0]                 w_alu_sum;
    logic                        w_alu_ge;
    logic                        w_wake_we;
    logic [31:0]                 w_wake_rdata;
    logic                        w_sp_we;
    logic [SW-1:0]               w_sp_waddr;
    logic [31:0]                 w_sp_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_slot     = SW'(i_task_slot);
    assign w_slot_ok  = 32'(i_task_slot) < 32'(NT);
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        for (int i = 0; i < NT; i++) begin
            w_ready[i]   = (r_ts[i] == rrts_pkg::TS_READY);
            w_running[i] = (r_ts[i] == rrts_pkg::TS_RUNNING);
        end
    end

    assign w_hit = (r_idx != '0) && w_ready[r_idx];

    always_comb begin
        w_alu_req.sub = 1'b1;
        w_alu_req.a   = r_tick;
        w_alu_req.b   = w_wake_rdata;
        if (r_state == S_IDLE) begin
            w_alu_req.sub = 1'b0;
            w_alu_req.b   = (i_op == rrts_pkg::OP_TICK) ? 32'd1 : i_delay_amount;
        end
    end

    rrts_alu u_alu (
        .i_req (w_alu_req),
        .o_sum (w_alu_sum),
        .o_ge  (w_alu_ge)
    );

    assign w_wake_we = w_in_acc && (i_op == rrts_pkg::OP_DELAY) && (r_cur != '0);

    rrts_ram #(
        .DEPTH (NT),
        .WIDTH (32)
    ) u_wake_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wake_we),
        .i_waddr (r_cur),
        .i_wdata (w_alu_sum),
        .i_re    (r_state == S_WAKE),
        .i_raddr (r_idx),
        .o_rdata (w_wake_rdata)
    );

    always_comb begin
        w_sp_we    = 1'b0;
        w_sp_waddr = r_cur;
        if (w_in_acc) begin
            case (i_op)
                rrts_pkg::OP_SWITCH: begin
                    w_sp_we = 1'b1;
                end
                rrts_pkg::OP_INIT: begin
                    w_sp_we    = w_slot_ok;
                    w_sp_waddr = w_slot;
                end
                default: begin
                    w_sp_we = 1'b0;
                end
            endcase
        end
    end

    rrts_ram #(
        .DEPTH (NT),
        .WIDTH (32)
    ) u_sp_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_sp_we),
        .i_waddr (w_sp_waddr),
        .i_wdata (i_stack_pointer),
        .i_re    (r_state == S_RD),
        .i_raddr (r_cur),
        .o_rdata (w_sp_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_chk   = r_chk;
        n_chk_v = r_chk_v;
        n_req   = r_req;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_req   = 1'b0;
                    n_chk_v = 1'b0;
                    n_state = S_RD;
                    case (i_op)
                        rrts_pkg::OP_TICK: begin
                            n_tick  = w_alu_sum;
                            n_req   = 1'b1;
                            n_idx   = SW'(1);
                            n_state = S_WAKE;
                        end
                        rrts_pkg::OP_DELAY: begin
                            n_req = (r_cur != '0);
                        end
                        rrts_pkg::OP_SWITCH: begin
                            n_idx   = (r_cur == rrts_pkg::LAST_SLOT) ? '0 : r_cur + 1'b1;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_WAKE: begin
                n_chk   = r_idx;
                n_chk_v = 1'b1;
                if (r_idx == rrts_pkg::LAST_SLOT) begin
                    n_state = S_WLAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WLAST: begin
                n_chk_v = 1'b0;
                n_state = S_RD;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_cur   = r_idx;
                    n_state = S_RD;
                end else if (r_cnt == rrts_pkg::LAST_SLOT) begin
                    n_cur   = '0;
                    n_state = S_RD;
                end else begin
                    n_idx = (r_idx == rrts_pkg::LAST_SLOT) ? '0 : r_idx + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NT; i++) begin
            n_ts[i] = r_ts[i];
            if (w_in_acc) begin
                case (i_op)
                    rrts_pkg::OP_DELAY: begin
                        if (r_cur != '0 && r_cur == SW'(i)) begin
                            n_ts[i] = rrts_pkg::TS_BLOCKED;
                        end
                    end
                    rrts_pkg::OP_SWITCH: begin
                        if (r_cur == SW'(i) && r_ts[i] == rrts_pkg::TS_RUNNING) begin
                            n_ts[i] = rrts_pkg::TS_READY;
                        end
                    end
                    rrts_pkg::OP_INIT: begin
                        if (w_slot_ok && w_slot == SW'(i)) begin
                            n_ts[i] = rrts_pkg::TS_READY;
                        end
                    end
                    default: begin
                        n_ts[i] = r_ts[i];
                    end
                endcase
            end
            if ((r_state == S_WAKE || r_state == S_WLAST) && r_chk_v && r_chk == SW'(i)
                && r_ts[i] == rrts_pkg::TS_BLOCKED && w_alu_ge) begin
                n_ts[i] = rrts_pkg::TS_READY;
            end
            if (r_state == S_SCAN) begin
                if (w_hit && r_idx == SW'(i)) begin
                    n_ts[i] = rrts_pkg::TS_RUNNING;
                end else if (!w_hit && r_cnt == rrts_pkg::LAST_SLOT && i == 0) begin
                    n_ts[i] = rrts_pkg::TS_RUNNING;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_chk       <= '0;
            r_chk_v     <= 1'b0;
            r_req       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                r_ts[i] <= (i == 0) ? rrts_pkg::TS_RUNNING : rrts_pkg::TS_BLOCKED;
            end
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_cur   <= n_cur;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
            r_chk_v <= n_chk_v;
            r_req   <= n_req;
            for (int i = 0; i < NT; i++) begin
                r_ts[i] <= n_ts[i];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_task <= 3'(r_cur);
            r_out_ptr  <= w_sp_rdata;
            r_out_req  <= r_req;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_running_task   = r_out_task;
    assign o_resume_pointer = r_out_ptr;
    assign o_switch_request = r_out_req;

    `RRTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_in_ready, "ready early")
    `RRTS_ASSERT(a_one_running, i_clk, i_rst_n, $countones(w_running) <= 1, "two running")
    `RRTS_ASSERT(a_load_from_out, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_OUT), "bad load")
    `RRTS_ASSERT(a_cur_in_range, i_clk, i_rst_n, 32'(r_cur) < 32'(NT), "slot out of range")

endmodule
